// ===== rtl/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// afs_pkg
// Types and constants shared by the ADTS frame synchronizer.
// ----------------------------------------------------------------------------
package afs_pkg;

   typedef enum logic [1:0] {
      MODE_HUNT  = 2'd0,
      MODE_FRAME = 2'd1,
      MODE_LOST  = 2'd2
   } mode_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [1:0] STATUS_SYNC_LOST = 2'd2;
   localparam logic [1:0] STATUS_NO_FRAME  = 2'd3;

   localparam int          HDR_BYTES      = 6;
   localparam logic [2:0]  HDR_COUNT      = 3'd6;
   localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
   localparam logic [3:0]  SYNC_NIBBLE    = 4'hF;
   localparam logic [12:0] MIN_LENGTH     = 13'd7;
   localparam logic [12:0] HDR_LENGTH     = 13'd6;
   localparam logic [15:0] SCAN_LIMIT_RST = 16'd32768;

endpackage

// ===== rtl/adts_frame_sync.sv =====
// ----------------------------------------------------------------------------
// adts_frame_sync: ADTS frame synchronizer, one stream byte per cycle while
// the output is ready. A byte's first result beat is presented next cycle.
// A matched header leaves a burst of six beats, holding off input until its
// last beat; other bytes give at most one beat each. Reset is synchronous.
// ----------------------------------------------------------------------------
module adts_frame_sync (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   input  logic        req_byte_present,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_frame_start,
   output logic        rsp_frame_end,
   output logic [12:0] rsp_frame_length,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_scan_limit
);

   import afs_pkg::*;

   logic [15:0] scan_limit_ff;
   logic [47:0] window_ff, window_in;
   logic [2:0]  win_count_ff, win_count_in;
   mode_type    mode_ff, mode_in;
   logic [12:0] bytes_left_ff, bytes_left_in;
   logic [15:0] tested_ff, tested_in;
   logic [12:0] cur_length_ff, cur_length_in;

   logic [47:0] buf_bytes_ff, buf_bytes_in;
   logic [2:0]  buf_count_ff, buf_count_in;
   logic        buf_valid_ff, buf_valid_in;
   logic        buf_start_ff, buf_start_in;
   logic        buf_end_ff, buf_end_in;
   logic [1:0]  buf_status_ff, buf_status_in;
   logic [12:0] buf_length_ff, buf_length_in;

   logic        req_beat;
   logic        rsp_beat;
   logic [47:0] win_shift;
   logic [2:0]  win_count_inc;
   logic [12:0] hdr_length;
   logic        hdr_match;
   logic [12:0] left_dec;

   assign csr_ready = 1'b1;
   assign req_ready = (buf_count_ff == 3'd0) || ((buf_count_ff == 3'd1) && rsp_ready);
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;

   assign win_shift     = {window_ff[39:0], req_data_byte};
   assign win_count_inc = (win_count_ff < HDR_COUNT) ? win_count_ff + 3'd1 : win_count_ff;
   assign hdr_length    = {win_shift[17:16], win_shift[15:8], win_shift[7:5]};
   assign hdr_match     = (win_shift[47:40] == SYNC_BYTE) &&
                          (win_shift[39:36] == SYNC_NIBBLE) &&
                          (win_shift[34:33] == 2'b00) &&
                          (hdr_length >= MIN_LENGTH);
   assign left_dec      = bytes_left_ff - 13'd1;

   always_comb begin
      logic       frame_done;
      logic       lost_now;
      logic [2:0] res_count;
      logic [47:0] res_bytes;
      logic       res_valid;
      logic       res_start;
      logic       res_end;
      logic [1:0] res_status;
      logic [12:0] res_length;

      frame_done = 1'b0;
      lost_now   = 1'b0;
      res_count  = 3'd0;
      res_bytes  = '0;
      res_valid  = 1'b0;
      res_start  = 1'b0;
      res_end    = 1'b0;
      res_status = STATUS_OK;
      res_length = '0;

      window_in     = window_ff;
      win_count_in  = win_count_ff;
      mode_in       = mode_ff;
      bytes_left_in = bytes_left_ff;
      tested_in     = tested_ff;
      cur_length_in = cur_length_ff;

      buf_bytes_in  = buf_bytes_ff;
      buf_count_in  = buf_count_ff;
      buf_valid_in  = buf_valid_ff;
      buf_start_in  = buf_start_ff;
      buf_end_in    = buf_end_ff;
      buf_status_in = buf_status_ff;
      buf_length_in = buf_length_ff;

      if (rsp_beat) begin
         buf_bytes_in = {buf_bytes_ff[39:0], 8'h00};
         buf_count_in = buf_count_ff - 3'd1;
         buf_start_in = 1'b0;
      end

      if (req_beat) begin
         if (req_byte_present) begin
            case (mode_ff)
               MODE_FRAME: begin
                  bytes_left_in = left_dec;
                  res_count     = 3'd1;
                  res_bytes     = {req_data_byte, 40'h0};
                  res_valid     = 1'b1;
                  res_end       = (left_dec == 13'd0);
                  res_length    = cur_length_ff;
                  if (left_dec == 13'd0) begin
                     mode_in    = MODE_HUNT;
                     tested_in  = '0;
                     frame_done = 1'b1;
                  end
               end
               MODE_LOST: begin
               end
               default: begin
                  window_in    = win_shift;
                  win_count_in = win_count_inc;
                  if (win_count_inc >= HDR_COUNT) begin
                     if (tested_ff >= scan_limit_ff) begin
                        res_count  = 3'd1;
                        res_end    = 1'b1;
                        res_status = STATUS_SYNC_LOST;
                        mode_in    = MODE_LOST;
                        lost_now   = 1'b1;
                     end else begin
                        tested_in = tested_ff + 16'd1;
                        if (hdr_match) begin
                           res_count     = 3'(HDR_BYTES);
                           res_bytes     = win_shift;
                           res_valid     = 1'b1;
                           res_start     = 1'b1;
                           res_length    = hdr_length;
                           cur_length_in = hdr_length;
                           bytes_left_in = hdr_length - HDR_LENGTH;
                           mode_in       = MODE_FRAME;
                           tested_in     = '0;
                           window_in     = '0;
                           win_count_in  = '0;
                        end
                     end
                  end
               end
            endcase
         end

         if (req_end_of_stream) begin
            if (mode_in == MODE_FRAME) begin
               if (res_count != 3'd0) begin
                  res_end    = 1'b1;
                  res_status = STATUS_TRUNCATED;
               end else begin
                  res_count  = 3'd1;
                  res_end    = 1'b1;
                  res_length = cur_length_ff;
                  res_status = STATUS_TRUNCATED;
               end
            end else if (mode_in == MODE_HUNT && !frame_done && !lost_now) begin
               res_count  = 3'd1;
               res_end    = 1'b1;
               res_status = STATUS_NO_FRAME;
            end
            window_in     = '0;
            win_count_in  = '0;
            mode_in       = MODE_HUNT;
            bytes_left_in = '0;
            tested_in     = '0;
            cur_length_in = '0;
         end

         if (res_count != 3'd0) begin
            buf_bytes_in  = res_bytes;
            buf_count_in  = res_count;
            buf_valid_in  = res_valid;
            buf_start_in  = res_start;
            buf_end_in    = res_end;
            buf_status_in = res_status;
            buf_length_in = res_length;
         end
      end
   end

   always_comb begin
      rsp_valid        = (buf_count_ff != 3'd0);
      rsp_out_byte     = buf_bytes_ff[47:40];
      rsp_byte_valid   = buf_valid_ff;
      rsp_frame_start  = buf_start_ff;
      rsp_frame_length = buf_length_ff;
      rsp_frame_end    = (buf_count_ff == 3'd1) ? buf_end_ff : 1'b0;
      rsp_status       = (buf_count_ff == 3'd1) ? buf_status_ff : STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_limit_ff <= SCAN_LIMIT_RST;
         window_ff     <= '0;
         win_count_ff  <= '0;
         mode_ff       <= MODE_HUNT;
         bytes_left_ff <= '0;
         tested_ff     <= '0;
         cur_length_ff <= '0;
         buf_count_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            scan_limit_ff <= csr_scan_limit;
         end
         window_ff     <= window_in;
         win_count_ff  <= win_count_in;
         mode_ff       <= mode_in;
         bytes_left_ff <= bytes_left_in;
         tested_ff     <= tested_in;
         cur_length_ff <= cur_length_in;
         buf_count_ff  <= buf_count_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_bytes_ff  <= buf_bytes_in;
      buf_valid_ff  <= buf_valid_in;
      buf_start_ff  <= buf_start_in;
      buf_end_ff    <= buf_end_in;
      buf_status_ff <= buf_status_in;
      buf_length_ff <= buf_length_in;
   end

endmodule

// ===== verif/adts_frame_sync_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adts_frame_sync_test
// Drives ADTS byte streams into the frame synchronizer with random gaps on
// both sides. A scoreboard tracks the sync state and checks every beat.
// ----------------------------------------------------------------------------
module adts_frame_sync_test;

   import afs_pkg::*;

   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int HOLD_CYCLES  = 80;
   localparam int IDLE_PAUSE   = 4;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int PHASE_ITEMS  = 28;
   localparam int PHASES       = 6;

   localparam int END_ON_LAST  = 0;
   localparam int END_CUT      = 1;
   localparam int END_MARK     = 2;
   localparam int END_GARBAGE  = 3;
   localparam int END_NONE     = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
      logic       byte_present;
   } stream_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        frame_start;
      logic        frame_end;
      logic [12:0] frame_length;
      logic [1:0]  status;
   } sync_beat_type;

   class adts_sync_scoreboard;
      logic [15:0]   scan_limit;
      mode_type      mode;
      logic [47:0]   window;
      logic [2:0]    fill;
      logic [12:0]   bytes_left;
      logic [15:0]   tested;
      logic [12:0]   cur_length;
      sync_beat_type pending_beats[$];
      int            errors;
      int            checked;
      int            bytes_in;
      int            frames;
      int            truncations;
      int            losses;
      int            empty_ends;

      function new();
         scan_limit = SCAN_LIMIT_RST;
         restart();
      endfunction

      function void restart();
         mode = MODE_HUNT;
         window = '0;
         fill = '0;
         bytes_left = '0;
         tested = '0;
         cur_length = '0;
      endfunction

      function sync_beat_type make_beat(logic [7:0] b, logic valid, logic first, logic last,
                                        logic [12:0] len, logic [1:0] st);
         sync_beat_type r;
         r.out_byte = b;
         r.byte_valid = valid;
         r.frame_start = first;
         r.frame_end = last;
         r.frame_length = len;
         r.status = st;
         return r;
      endfunction

      function void note_stream_byte(stream_item_type it);
         sync_beat_type batch[$];
         logic [12:0]   len;
         logic [7:0]    hb;
         bit            frame_done;
         bit            lost_now;
         frame_done = 0;
         lost_now = 0;
         if (it.byte_present) begin
            bytes_in++;
            case (mode)
               MODE_FRAME: begin
                  bytes_left = bytes_left - 13'd1;
                  batch.push_back(make_beat(it.data_byte, 1'b1, 1'b0, bytes_left == 0,
                                            cur_length, STATUS_OK));
                  if (bytes_left == 0) begin
                     mode = MODE_HUNT;
                     tested = '0;
                     frame_done = 1;
                  end
               end
               MODE_HUNT: begin
                  window = {window[39:0], it.data_byte};
                  if (fill < HDR_COUNT) fill++;
                  if (fill == HDR_COUNT) begin
                     if (tested >= scan_limit) begin
                        batch.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b1, 13'd0,
                                                  STATUS_SYNC_LOST));
                        mode = MODE_LOST;
                        lost_now = 1;
                        losses++;
                     end else begin
                        len = {window[17:16], window[15:8], window[7:5]};
                        tested = tested + 16'd1;
                        if (window[47:40] == SYNC_BYTE && window[39:36] == SYNC_NIBBLE &&
                            window[34:33] == 2'b00 && len >= MIN_LENGTH) begin
                           for (int i = 0; i < HDR_BYTES; i++) begin
                              hb = window[47 - 8 * i -: 8];
                              batch.push_back(make_beat(hb, 1'b1, i == 0, 1'b0, len,
                                                        STATUS_OK));
                           end
                           cur_length = len;
                           bytes_left = len - HDR_LENGTH;
                           mode = MODE_FRAME;
                           tested = '0;
                           window = '0;
                           fill = '0;
                           frames++;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         if (it.end_of_stream) begin
            if (mode == MODE_FRAME) begin
               truncations++;
               if (batch.size() > 0) begin
                  batch[batch.size() - 1].frame_end = 1'b1;
                  batch[batch.size() - 1].status = STATUS_TRUNCATED;
               end else begin
                  batch.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b1, cur_length,
                                            STATUS_TRUNCATED));
               end
            end else if (mode == MODE_HUNT && !frame_done && !lost_now) begin
               batch.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b1, 13'd0, STATUS_NO_FRAME));
               empty_ends++;
            end
            restart();
         end
         foreach (batch[i]) pending_beats.push_back(batch[i]);
      endfunction

      function void compare(string field, logic [12:0] want, logic [12:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_output_beat(sync_beat_type got);
         sync_beat_type want;
         if (pending_beats.size() == 0) begin
            $error("Result beat arrived with nothing pending: byte 0x%0h, status %0d.",
                   got.out_byte, got.status);
            errors++;
            return;
         end
         want = pending_beats.pop_front();
         checked++;
         compare("out_byte", 13'(want.out_byte), 13'(got.out_byte));
         compare("byte_valid", 13'(want.byte_valid), 13'(got.byte_valid));
         compare("frame_start", 13'(want.frame_start), 13'(got.frame_start));
         compare("frame_end", 13'(want.frame_end), 13'(got.frame_end));
         compare("frame_length", want.frame_length, got.frame_length);
         compare("status", 13'(want.status), 13'(got.status));
      endfunction

      function int pending();
         return pending_beats.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_end_of_stream;
   logic        req_byte_present;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_frame_start;
   logic        rsp_frame_end;
   logic [12:0] rsp_frame_length;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_scan_limit;

   adts_sync_scoreboard sb;
   stream_item_type     stim[$];
   int                  item_count;
   int                  settings;
   bit                  req_quiet;
   bit                  rsp_quiet;
   bit                  hold_off;

   adts_frame_sync i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .req_byte_present  (req_byte_present),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_frame_start   (rsp_frame_start),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_scan_limit    (csr_scan_limit)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int draw_gap(bit quiet);
      return quiet ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic void push_item(logic [7:0] b, logic eos, logic present);
      stream_item_type it;
      it.data_byte = b;
      it.end_of_stream = eos;
      it.byte_present = present;
      stim.push_back(it);
      item_count++;
   endfunction

   function automatic void push_byte(logic [7:0] b, logic eos);
      if ($urandom_range(0, 11) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(b, eos, 1'b1);
   endfunction

   function automatic void push_header(logic [47:0] hdr, logic eos_last);
      for (int k = 0; k < HDR_BYTES; k++)
         push_item(hdr[47 - 8 * k -: 8], eos_last && k == HDR_BYTES - 1, 1'b1);
   endfunction

   function automatic void push_frame(int len, int ending);
      logic [12:0] l;
      logic [7:0]  hdr[6];
      int          total;
      int          stop;
      l = 13'(len);
      hdr[0] = SYNC_BYTE;
      hdr[1] = {SYNC_NIBBLE, 4'($urandom) & 4'b1001};
      hdr[2] = 8'($urandom);
      hdr[3] = {6'($urandom), l[12:11]};
      hdr[4] = l[10:3];
      hdr[5] = {l[2:0], 5'($urandom)};
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0: hdr[0][$urandom_range(0, 7)] = 1'b0;
            1: hdr[1][$urandom_range(1, 2)] = 1'b1;
            default: hdr[1][$urandom_range(4, 7)] = 1'b0;
         endcase
      end
      total = (len < MIN_LENGTH) ? HDR_BYTES : len;
      stop = (ending == END_CUT) ? $urandom_range(1, total) : total;
      for (int k = 0; k < stop; k++)
         push_byte(k < HDR_BYTES ? hdr[k] : 8'($urandom), ending != END_NONE && k == stop - 1);
   endfunction

   function automatic void push_stream();
      int nframes;
      int ending;
      int len;
      nframes = $urandom_range(1, 4);
      ending = $urandom_range(END_ON_LAST, END_GARBAGE);
      for (int f = 0; f < nframes; f++) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
         if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 6);
         else if ($urandom_range(0, 7) == 0) len = $urandom_range(21, 80);
         else len = $urandom_range(7, 20);
         push_frame(len, (f == nframes - 1 && ending <= END_CUT) ? ending : END_NONE);
      end
      if (ending == END_MARK) begin
         push_item(8'($urandom), 1'b1, 1'b0);
      end else if (ending == END_GARBAGE) begin
         repeat ($urandom_range(0, 7)) push_byte(8'($urandom), 1'b0);
         push_byte(8'($urandom), 1'b1);
      end
   endfunction

   task automatic send_item(stream_item_type it);
      int gap;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= it.data_byte;
      req_end_of_stream <= it.end_of_stream;
      req_byte_present <= it.byte_present;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_all();
      while (stim.size() != 0) send_item(stim.pop_front());
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (IDLE_PAUSE) @(negedge clock);
   endtask

   task automatic write_scan_limit(logic [15:0] value);
      csr_scan_limit <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_output_beat({rsp_out_byte, rsp_byte_valid, rsp_frame_start,
                                  rsp_frame_end, rsp_frame_length, rsp_status});
         if (req_valid && req_ready)
            sb.note_stream_byte({req_data_byte, req_end_of_stream, req_byte_present});
         if (csr_valid && csr_ready) sb.scan_limit = csr_scan_limit;
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         stall = draw_gap(rsp_quiet);
         if (hold_off) begin
            stall = HOLD_CYCLES;
            hold_off = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [15:0] limits[PHASES];
      int          guard;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_end_of_stream = 1'b0;
      req_byte_present = 1'b0;
      csr_valid = 1'b0;
      csr_scan_limit = '0;
      req_quiet = 0;
      rsp_quiet = 0;
      hold_off = 0;
      settings = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // An idle beat, an empty stream, a maximum length header cut on its last
      // byte, a minimum length frame cut by an end mark, and a length below
      // the minimum.
      write_scan_limit(16'hFFFF);
      push_item(8'hA5, 1'b0, 1'b0);
      push_item(8'h3C, 1'b1, 1'b0);
      push_header(48'hFFF0_0003_FFFF, 1'b1);
      push_header(48'hFFF9_1280_00E0, 1'b0);
      push_item(8'h00, 1'b1, 1'b0);
      push_header(48'hFFF1_0000_00C0, 1'b1);
      send_all();
      settle();

      // A scan limit of one loses sync at the second tested position.
      write_scan_limit(16'd1);
      repeat (7) push_item(8'h00, 1'b0, 1'b1);
      push_item(8'hFF, 1'b1, 1'b0);
      send_all();

      limits[0] = 16'd32768;
      limits[1] = 16'd1;
      limits[2] = 16'hFFFF;
      limits[3] = 16'($urandom_range(2, 12));
      limits[4] = 16'($urandom_range(1, 4));
      limits[5] = 16'($urandom_range(13, 65535));
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         write_scan_limit(limits[phase]);
         req_quiet = (phase == 0) || ($urandom_range(0, 3) == 0);
         rsp_quiet = (phase == 0) || ($urandom_range(0, 3) == 0);
         hold_off = (phase == 2);
         item_count = 0;
         while (item_count < PHASE_ITEMS) push_stream();
         send_all();
      end

      req_valid <= 1'b0;
      for (guard = 0; guard < DRAIN_LIMIT && sb.pending() != 0; guard++)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected result beats never arrived.", sb.pending());
         sb.errors++;
      end

      $display("Run covered %0d stream bytes, %0d frames, %0d truncations, %0d sync losses",
               sb.bytes_in, sb.frames, sb.truncations, sb.losses);
      $display("and %0d empty streams over %0d scan limit settings; %0d beats checked.",
               sb.empty_ends, settings, sb.checked);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/afs_pkg.sv
rtl/adts_frame_sync.sv
verif/adts_frame_sync_test.sv
